// ===== rtl/lkvc_pkg.sv =====
`timescale 1ns / 1ps

package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AGE_W   = IDX_W;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int LIM_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;

	localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;
	localparam logic [VAL_W-1:0] PUT_VALUE  = '0;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		AGE_NONE,
		AGE_TOUCH,
		AGE_INSERT
	} age_op_t;

	// recency update request from the sequencer
	typedef struct packed {
		age_op_t          op;
		logic [IDX_W-1:0] idx;
		logic [AGE_W-1:0] touch_age;
		logic             grow;
	} age_cmd_t;

	// what one pass over the store found
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [VAL_W-1:0] hit_val;
		logic [AGE_W-1:0] hit_age;
		logic             old_found;
		logic [IDX_W-1:0] old_idx;
		logic [AGE_W-1:0] old_age;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
	} scan_res_t;

endpackage

// ===== rtl/lru_key_value_cache_core.sv =====
`timescale 1ns / 1ps

// After accept, SCAN reads every entry, then DRAIN and UPDATE; DONE loads the
//   output register. A new request is taken only in IDLE, once the last result is
//   loaded; the single-port key/value store is read once per scan step.
// Reset (arst_n low): all entries invalid, ages and count zero, capacity 16.
//   Key/value storage is not cleared; no clearing pass is needed.
// A finished result waits in the output register while the next request is taken.
module lru_key_value_cache_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: capacity_in_use
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	// request
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [31:0] lookup_key, [63:32] store_value
	input  logic        s_axis_tuser,  // [0] cmd (0 get, 1 put)
	// result
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] read_value
	output logic [1:0]  m_axis_tuser   // [0] found, [1] evicted
);
	import lkvc_pkg::*;

	state_t state_q, state_d;

	// captured request
	logic             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	logic [CAP_W-1:0] capacity_q;

	// scan address and the compare stage, registered alongside the store read data
	logic [IDX_W-1:0] addr_q;
	logic             step_s1;
	logic [IDX_W-1:0] idx_s1;

	// result of the update cycle, handed to the output register
	logic             res_found_q, res_ev_q;
	logic [VAL_W-1:0] res_val_q;
	logic             res_found_d, res_ev_d;
	logic [VAL_W-1:0] res_val_d;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_val_q;
	logic             out_found_q, out_ev_q;

	logic             s_accept, m_accept, out_load;
	logic             scan_start;
	logic             st_we;
	logic [IDX_W-1:0] st_addr, wr_idx;
	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_val;
	logic             rd_valid;
	logic [AGE_W-1:0] rd_age;
	logic [CNT_W-1:0] count;
	logic [LIM_W-1:0] cap_ext, cap_eff;
	logic             full;
	scan_res_t        scan;
	age_cmd_t         age_cmd;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign m_accept      = m_axis_tvalid && m_axis_tready;
	assign scan_start    = s_accept;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tuser  = {out_ev_q, out_found_q};

	// capacity clipped to the store size; full means an insert must evict
	assign cap_ext = LIM_W'(capacity_q);
	assign cap_eff = (cap_ext > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES) : cap_ext;
	assign full    = LIM_W'(count) >= cap_eff;

	// store port: scan reads during SCAN, single write in UPDATE
	assign st_addr = (state_q == ST_UPDATE) ? wr_idx : addr_q;

	lkvc_store u_store (
		.clk    (clk),
		.we     (st_we),
		.addr   (st_addr),
		.wr_key (key_q),
		.wr_val (val_q),
		.rd_key (rd_key),
		.rd_val (rd_val)
	);

	lkvc_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (scan_start),
		.step        (step_s1),
		.idx         (idx_s1),
		.lookup_key  (key_q),
		.entry_key   (rd_key),
		.entry_val   (rd_val),
		.entry_valid (rd_valid),
		.entry_age   (rd_age),
		.res         (scan)
	);

	lkvc_age u_age (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (age_cmd),
		.rd_idx   (idx_s1),
		.rd_valid (rd_valid),
		.rd_age   (rd_age),
		.count    (count)
	);

	// sequencer: next state and per-request decisions
	always_comb begin
		state_d     = state_q;
		st_we       = 1'b0;
		wr_idx      = scan.hit_idx;
		age_cmd     = '0;
		age_cmd.op  = AGE_NONE;
		res_found_d = res_found_q;
		res_val_d   = res_val_q;
		res_ev_d    = res_ev_q;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (addr_q == IDX_W'(ENTRIES - 1))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d     = ST_DONE;
				res_found_d = scan.hit;
				res_ev_d    = 1'b0;
				if (cmd_q == CMD_GET) begin
					res_val_d = scan.hit ? scan.hit_val : MISS_VALUE;
					if (scan.hit) begin
						age_cmd.op        = AGE_TOUCH;
						age_cmd.idx       = scan.hit_idx;
						age_cmd.touch_age = scan.hit_age;
					end
				end else begin
					res_val_d = PUT_VALUE;
					if (scan.hit) begin
						// refresh value of a present key
						st_we             = 1'b1;
						age_cmd.op        = AGE_TOUCH;
						age_cmd.idx       = scan.hit_idx;
						age_cmd.touch_age = scan.hit_age;
					end else if (full && count == '0) begin
						// zero capacity, empty store: new entry dropped at once
						res_ev_d = 1'b1;
					end else if (full) begin
						// reuse the least recent slot
						res_ev_d    = 1'b1;
						wr_idx      = scan.old_idx;
						st_we       = 1'b1;
						age_cmd.op  = AGE_INSERT;
						age_cmd.idx = scan.old_idx;
					end else begin
						wr_idx       = scan.free_idx;
						st_we        = 1'b1;
						age_cmd.op   = AGE_INSERT;
						age_cmd.idx  = scan.free_idx;
						age_cmd.grow = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			addr_q      <= '0;
			step_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				capacity_q <= cfg_data;
			if (state_q == ST_SCAN)
				addr_q <= IDX_W'(addr_q + 1'b1);
			else
				addr_q <= '0;
			step_s1 <= (state_q == ST_SCAN);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_accept)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (s_accept) begin
			cmd_q <= s_axis_tuser;
			key_q <= s_axis_tdata[31:0];
			val_q <= s_axis_tdata[63:32];
		end
		res_found_q <= res_found_d;
		res_val_q   <= res_val_d;
		res_ev_q    <= res_ev_d;
		if (out_load) begin
			out_found_q <= res_found_q;
			out_val_q   <= res_val_q;
			out_ev_q    <= res_ev_q;
		end
	end

endmodule

// ===== rtl/lkvc_store.sv =====
`timescale 1ns / 1ps

module lkvc_store (
	input  logic                      clk,
	input  logic                      we,
	input  logic [lkvc_pkg::IDX_W-1:0] addr,
	input  logic [lkvc_pkg::KEY_W-1:0] wr_key,
	input  logic [lkvc_pkg::VAL_W-1:0] wr_val,
	output logic [lkvc_pkg::KEY_W-1:0] rd_key,
	output logic [lkvc_pkg::VAL_W-1:0] rd_val
);
	import lkvc_pkg::*;

	logic [KEY_W-1:0] key_mem [ENTRIES];
	logic [VAL_W-1:0] val_mem [ENTRIES];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[addr] <= wr_key;
			val_mem[addr] <= wr_val;
		end
		rd_key <= key_mem[addr];
		rd_val <= val_mem[addr];
	end

endmodule

// ===== rtl/lkvc_scan.sv =====
`timescale 1ns / 1ps

module lkvc_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       step,
	input  logic [lkvc_pkg::IDX_W-1:0] idx,
	input  logic [lkvc_pkg::KEY_W-1:0] lookup_key,
	input  logic [lkvc_pkg::KEY_W-1:0] entry_key,
	input  logic [lkvc_pkg::VAL_W-1:0] entry_val,
	input  logic                       entry_valid,
	input  logic [lkvc_pkg::AGE_W-1:0] entry_age,
	output lkvc_pkg::scan_res_t        res
);
	import lkvc_pkg::*;

	scan_res_t res_q;

	assign res = res_q;

	// one entry per step: key match, oldest valid entry, first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (start) begin
			res_q <= '0;
		end else if (step) begin
			if (entry_valid && !res_q.hit && entry_key == lookup_key) begin
				res_q.hit     <= 1'b1;
				res_q.hit_idx <= idx;
				res_q.hit_val <= entry_val;
				res_q.hit_age <= entry_age;
			end
			if (entry_valid && (!res_q.old_found || entry_age > res_q.old_age)) begin
				res_q.old_found <= 1'b1;
				res_q.old_idx   <= idx;
				res_q.old_age   <= entry_age;
			end
			if (!entry_valid && !res_q.free_found) begin
				res_q.free_found <= 1'b1;
				res_q.free_idx   <= idx;
			end
		end
	end

endmodule

// ===== rtl/lkvc_age.sv =====
`timescale 1ns / 1ps

module lkvc_age (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lkvc_pkg::age_cmd_t         cmd,
	input  logic [lkvc_pkg::IDX_W-1:0] rd_idx,
	output logic                       rd_valid,
	output logic [lkvc_pkg::AGE_W-1:0] rd_age,
	output logic [lkvc_pkg::CNT_W-1:0] count
);
	import lkvc_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic [AGE_W-1:0]   age_q [ENTRIES];
	logic [CNT_W-1:0]   count_q;

	assign rd_valid = valid_q[rd_idx];
	assign rd_age   = age_q[rd_idx];
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			age_q   <= '{default: '0};
			count_q <= '0;
		end else begin
			unique case (cmd.op)
				AGE_TOUCH: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i] && IDX_W'(i) != cmd.idx && age_q[i] < cmd.touch_age)
							age_q[i] <= AGE_W'(age_q[i] + 1'b1);
					end
					age_q[cmd.idx] <= '0;
				end
				AGE_INSERT: begin
					// slot reused on eviction keeps its valid bit
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i] && IDX_W'(i) != cmd.idx)
							age_q[i] <= AGE_W'(age_q[i] + 1'b1);
					end
					valid_q[cmd.idx] <= 1'b1;
					age_q[cmd.idx]   <= '0;
					if (cmd.grow)
						count_q <= CNT_W'(count_q + 1'b1);
				end
				default: begin
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count above store size");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("entry count disagrees with valid bits");

	a_insert_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == AGE_INSERT |=> valid_q[$past(cmd.idx)] && age_q[$past(cmd.idx)] == '0)
		else $error("inserted entry not valid and most recent");

endmodule
